[rtl/core/dsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dsp_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_Y  = 8'h79;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_LC_N  = 8'h6E;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_UNIT   = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_BAD_UNIT  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    UNIT_Y  = 3'd0,
    UNIT_D  = 3'd1,
    UNIT_H  = 3'd2,
    UNIT_M  = 3'd3,
    UNIT_S  = 3'd4,
    UNIT_MS = 3'd5,
    UNIT_US = 3'd6,
    UNIT_NS = 3'd7
  } unit_e;

  typedef struct packed {
    logic  known;
    unit_e unit;
  } unit_cls_t;

  // one request from the front to the back
  typedef struct packed {
    logic        add;
    logic        last;
    logic        zero;
    logic        neg;
    unit_e       unit;
    status_e     status;
    logic [63:0] mag;
  } term_t;

  typedef struct packed {
    logic [63:0] duration;
    status_e     status;
  } result_t;

  function automatic unit_cls_t classify(input logic [7:0] first, input logic [7:0] second,
                                         input logic [1:0] len);
    unit_cls_t c;
    c.known = 1'b1;
    c.unit  = UNIT_NS;
    if (len == 2'd1) begin
      unique case (first)
        CH_LC_Y: c.unit = UNIT_Y;
        CH_LC_D: c.unit = UNIT_D;
        CH_LC_H: c.unit = UNIT_H;
        CH_LC_M: c.unit = UNIT_M;
        CH_LC_S: c.unit = UNIT_S;
        default: c.known = 1'b0;
      endcase
    end else if (len == 2'd2 && second == CH_LC_S) begin
      unique case (first)
        CH_LC_M: c.unit = UNIT_MS;
        CH_LC_U: c.unit = UNIT_US;
        CH_LC_N: c.unit = UNIT_NS;
        default: c.known = 1'b0;
      endcase
    end else begin
      c.known = 1'b0;
    end
    return c;
  endfunction

  function automatic logic [63:0] scale_of(input unit_e u);
    logic [63:0] s;
    unique case (u)
      UNIT_Y:  s = 64'd31556952000000000;
      UNIT_D:  s = 64'd86400000000000;
      UNIT_H:  s = 64'd3600000000000;
      UNIT_M:  s = 64'd60000000000;
      UNIT_S:  s = 64'd1000000000;
      UNIT_MS: s = 64'd1000000;
      UNIT_US: s = 64'd1000;
      UNIT_NS: s = 64'd1;
      default: s = 64'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dsp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module dsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dsp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module dsp_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        last_i,
  input  wire logic        empty_req_i,
  output logic             term_push_o,
  output dsp_pkg::term_t   term_o
);

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_MINUS  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_UNIT   = 4'b1000
  } phase_e;

  localparam logic [67:0] LIMIT_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] LIMIT_NEG = 68'h0_8000_0000_0000_0000;

  phase_e           phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [63:0]      mag_q, mag_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       u1_q, u1_d, u2_q, u2_d;
  logic [1:0]       ulen_q, ulen_d;
  dsp_pkg::status_e err_q, err_d;

  logic             accept, is_digit, emit;
  logic [3:0]       digit;
  logic [67:0]      grown;
  dsp_pkg::unit_cls_t cls_cur;

  assign accept   = push_i & ~full_i;
  assign is_digit = (char_code_i >= dsp_pkg::CH_ZERO) && (char_code_i <= dsp_pkg::CH_NINE);
  assign digit    = 4'(char_code_i - dsp_pkg::CH_ZERO);
  // magnitude * 10 + digit, wide enough never to wrap
  assign grown    = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {64'b0, digit};
  assign cls_cur  = dsp_pkg::classify(u1_q, u2_q, ulen_q);

  always_comb begin
    dsp_pkg::unit_cls_t cls_fin;
    logic clr;
    cls_fin = '0;
    clr     = 1'b0;
    emit    = 1'b0;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ovf_d   = ovf_q;
    u1_d    = u1_q;
    u2_d    = u2_q;
    ulen_d  = ulen_q;
    err_d   = err_q;
    term_o.add    = 1'b0;
    term_o.last   = 1'b0;
    term_o.zero   = 1'b0;
    term_o.neg    = neg_q;
    term_o.unit   = dsp_pkg::UNIT_NS;
    term_o.status = dsp_pkg::ST_OK;
    term_o.mag    = mag_q;

    if (empty_req_i) begin
      term_o.last = 1'b1;
      term_o.zero = 1'b1;
      emit        = 1'b1;
      clr         = 1'b1;
    end else begin
      if (err_q == dsp_pkg::ST_OK) begin
        unique case (phase_q)
          PH_START: begin
            if (is_digit) begin
              phase_d = PH_DIGITS;
              mag_d   = {60'b0, digit};
            end else if (char_code_i == dsp_pkg::CH_MINUS) begin
              neg_d   = 1'b1;
              phase_d = PH_MINUS;
            end else begin
              err_d = dsp_pkg::ST_BAD_COUNT;
            end
          end
          PH_MINUS: begin
            if (is_digit) begin
              phase_d = PH_DIGITS;
              mag_d   = {60'b0, digit};
            end else begin
              err_d = dsp_pkg::ST_BAD_COUNT;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              if (!ovf_q) begin
                if (grown > (neg_q ? LIMIT_NEG : LIMIT_POS)) begin
                  ovf_d = 1'b1;
                end else begin
                  mag_d = grown[63:0];
                end
              end
            end else if (ovf_q) begin
              err_d = dsp_pkg::ST_TOO_LARGE;
            end else begin
              phase_d = PH_UNIT;
              u1_d    = char_code_i;
              u2_d    = 8'h00;
              ulen_d  = 2'd1;
            end
          end
          PH_UNIT: begin
            if (is_digit) begin
              if (!cls_cur.known) begin
                err_d = dsp_pkg::ST_BAD_UNIT;
              end else begin
                // finished term goes to the back, a new one starts here
                term_o.add  = 1'b1;
                term_o.unit = cls_cur.unit;
                emit        = 1'b1;
                phase_d     = PH_DIGITS;
                neg_d       = 1'b0;
                ovf_d       = 1'b0;
                u1_d        = 8'h00;
                u2_d        = 8'h00;
                ulen_d      = 2'd0;
                mag_d       = {60'b0, digit};
              end
            end else begin
              if (ulen_q == 2'd1) begin
                u2_d = char_code_i;
              end
              if (ulen_q != 2'd3) begin
                ulen_d = ulen_q + 2'd1;
              end
            end
          end
          default: phase_d = PH_START;
        endcase
      end

      if (last_i) begin
        if (err_d == dsp_pkg::ST_OK) begin
          unique case (phase_d) inside
            PH_START, PH_MINUS: err_d = dsp_pkg::ST_BAD_COUNT;
            PH_DIGITS:          err_d = dsp_pkg::ST_NO_UNIT;
            PH_UNIT: begin
              cls_fin = dsp_pkg::classify(u1_d, u2_d, ulen_d);
              if (!cls_fin.known) begin
                err_d = dsp_pkg::ST_BAD_UNIT;
              end
            end
            default: err_d = dsp_pkg::ST_BAD_COUNT;
          endcase
        end
        term_o.last   = 1'b1;
        term_o.status = err_d;
        term_o.add    = (err_d == dsp_pkg::ST_OK);
        term_o.unit   = cls_fin.unit;
        term_o.neg    = neg_d;
        term_o.mag    = mag_d;
        emit          = 1'b1;
        clr           = 1'b1;
      end
    end

    if (clr) begin
      phase_d = PH_START;
      neg_d   = 1'b0;
      mag_d   = '0;
      ovf_d   = 1'b0;
      u1_d    = 8'h00;
      u2_d    = 8'h00;
      ulen_d  = 2'd0;
      err_d   = dsp_pkg::ST_OK;
    end
  end

  assign term_push_o = accept & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      u1_q    <= 8'h00;
      u2_q    <= 8'h00;
      ulen_q  <= 2'd0;
      err_q   <= dsp_pkg::ST_OK;
    end else if (accept) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
      u1_q    <= u1_d;
      u2_q    <= u2_d;
      ulen_q  <= ulen_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dsp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module dsp_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        term_valid_i,
  input  wire dsp_pkg::term_t term_i,
  output logic             term_pop_o,
  output logic             res_push_o,
  input  wire logic        res_full_i,
  output dsp_pkg::result_t res_o
);

  typedef struct packed {
    logic             add;
    logic             last;
    logic             zero;
    logic             neg;
    dsp_pkg::status_e status;
  } ctrl_t;

  logic        s1_v_q, s2_v_q;
  ctrl_t       s1_c_q, s2_c_q;
  logic [63:0] p_ll_q;
  logic [31:0] p_hl_q, p_lh_q;
  logic [63:0] prod_q;
  logic [63:0] total_q;

  logic        adv;
  logic [63:0] scale, m_ll, total_nx;
  logic [31:0] m_hl, m_lh;
  ctrl_t       in_c;

  // the whole pipe holds while a finished string waits for result space
  assign adv        = ~(s2_v_q & s2_c_q.last & res_full_i);
  assign term_pop_o = adv & term_valid_i;

  assign in_c.add    = term_i.add;
  assign in_c.last   = term_i.last;
  assign in_c.zero   = term_i.zero;
  assign in_c.neg    = term_i.neg;
  assign in_c.status = term_i.status;

  // product modulo 2^64 from three 32x32 partials
  assign scale = dsp_pkg::scale_of(term_i.unit);
  assign m_ll  = {32'b0, term_i.mag[31:0]} * {32'b0, scale[31:0]};
  assign m_hl  = term_i.mag[63:32] * scale[31:0];
  assign m_lh  = term_i.mag[31:0] * scale[63:32];

  always_comb begin
    total_nx = total_q;
    if (s2_c_q.add) begin
      total_nx = s2_c_q.neg ? total_q - prod_q : total_q + prod_q;
    end
  end

  assign res_push_o      = adv & s2_v_q & s2_c_q.last;
  assign res_o.duration  = (s2_c_q.zero || s2_c_q.status != dsp_pkg::ST_OK) ? 64'd0 : total_nx;
  assign res_o.status    = s2_c_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      total_q <= '0;
    end else if (adv) begin
      s1_v_q <= term_valid_i;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        total_q <= s2_c_q.last ? 64'd0 : total_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_c_q <= in_c;
      p_ll_q <= m_ll;
      p_hl_q <= m_hl;
      p_lh_q <= m_lh;
      s2_c_q <= s1_c_q;
      prod_q <= p_ll_q + {p_hl_q + p_lh_q, 32'b0};
    end
  end

endmodule

`default_nettype wire

[rtl/core/duration_string_parser.sv]
// channel   direction  handshake       payload
// input     in         push_i/full_o   char_code_i[7:0], last_i, empty_req_i
// result    out        pop_i/empty_o   duration_ns_o[63:0] (signed), status_o[2:0]
//
// one byte is taken every cycle while full_o is low; full_o rises when the term queue is full
// a string's result enters the result queue after the term of its last byte passes through
// the term queue write, then the partial-product and product stages
// the back stalls only while a finished string finds the result queue full
// reset is asynchronous, active low, and empties both queues and the parse state
`timescale 1ns / 1ps
`default_nettype none

module duration_string_parser #(
  parameter int TERM_DEPTH   = 4,
  parameter int RESULT_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               last_i,
  input  wire logic               empty_req_i,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic signed [63:0]      duration_ns_o,
  output logic [2:0]              status_o
);

  localparam int TW = $bits(dsp_pkg::term_t);
  localparam int RW = $bits(dsp_pkg::result_t);

  logic             term_push, tq_empty, term_pop, res_push, rq_full;
  dsp_pkg::term_t   term_in, term_out;
  logic [TW-1:0]    tq_rd;
  dsp_pkg::result_t res_in, res_out;
  logic [RW-1:0]    rq_rd;

  dsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_i      (full_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .empty_req_i (empty_req_i),
    .term_push_o (term_push),
    .term_o      (term_in)
  );

  dsp_fifo #(
    .WIDTH (TW),
    .DEPTH (TERM_DEPTH)
  ) u_term_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (term_push),
    .data_i  (term_in),
    .full_o  (full_o),
    .pop_i   (term_pop),
    .data_o  (tq_rd),
    .empty_o (tq_empty)
  );

  assign term_out = dsp_pkg::term_t'(tq_rd);

  dsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_valid_i (~tq_empty),
    .term_i       (term_out),
    .term_pop_o   (term_pop),
    .res_push_o   (res_push),
    .res_full_i   (rq_full),
    .res_o        (res_in)
  );

  dsp_fifo #(
    .WIDTH (RW),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (rq_full),
    .pop_i   (pop_i),
    .data_o  (rq_rd),
    .empty_o (empty_o)
  );

  assign res_out       = dsp_pkg::result_t'(rq_rd);
  assign duration_ns_o = res_out.duration;
  assign status_o      = res_out.status;

endmodule

`default_nettype wire
